### rtl/core/mer_pkg.sv
// Shared types, widths and the microcode program of the midpoint ellipse rasterizer.
package mer_pkg;

  // Radius and derived datapath widths
  localparam int RADIUS_BITS = 11;
  localparam int SQ_W        = 2 * RADIUS_BITS;   // radius squared
  localparam int PROD_W      = 3 * RADIUS_BITS;   // a_sq * b
  localparam int DEL_W       = PROD_W + 3;        // delta_x / delta_y, signed
  localparam int DEC_W       = PROD_W + 7;        // decision and scratch, signed
  localparam int POS_W       = RADIUS_BITS + 1;   // cur_x / cur_y, signed
  localparam int COORD_W     = 17;                // output coordinates
  localparam int CENTER_W    = 16;
  localparam int RIN_W       = 11;                // radius field width on the bus
  localparam int CFG_W       = 12;
  localparam int CFG_AW      = 1;
  localparam int TDATA_W     = 56;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_WINDOW_LEFT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_WINDOW_TOP  = 1'b1;

  // Input item kinds
  localparam logic OPER_START = 1'b0;
  localparam logic OPER_STEP  = 1'b1;

  // Rasterizer phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_R1   = 3'b010,
    PH_R2   = 3'b100
  } phase_t;

  // Micro-operations executed by the datapath
  typedef enum logic [4:0] {
    OP_NOP,
    OP_SQ,
    OP_MULB,
    OP_DINIT1,
    OP_DINIT2,
    OP_YDEC,
    OP_D_SUB_DY,
    OP_XINC,
    OP_D_ADD_BSQ,
    OP_D_ADD_DX,
    OP_D_ADD_ASQ,
    OP_T_DIFF,
    OP_T_TRIPLE,
    OP_T_HALF,
    OP_T_SUB_DX,
    OP_T_SUB_DY,
    OP_D_ADD_T,
    OP_CHKY,
    OP_EMIT,
    OP_FINISH
  } uop_t;

  // Jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_D_NOT_POS,
    CND_IN_R2,
    CND_D_NOT_NEG,
    CND_DX_LT_DY
  } cond_t;

  localparam int PC_W = 5;

  // Program entry points and jump targets
  localparam logic [PC_W-1:0] PC_START = PC_W'(0);
  localparam logic [PC_W-1:0] PC_STEP  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_R1_X  = PC_W'(8);
  localparam logic [PC_W-1:0] PC_R2    = PC_W'(19);
  localparam logic [PC_W-1:0] PC_R2_Y  = PC_W'(22);
  localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(26);

  typedef struct packed {
    uop_t              op;
    cond_t             cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic en;
    uop_t op;
  } dp_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic d_pos;
    logic d_neg;
    logic dx_lt_dy;
    logic in_r2;
    logic emit_ok;
    logic emit_last;
  } dp_flags_t;

  function automatic uword_t uw(input uop_t op, input cond_t cond,
                                input logic [PC_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store: start setup, region 1, transition, region 2, emit
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_W'(0):  w = uw(OP_SQ,        CND_NEVER,     PC_START);
      PC_W'(1):  w = uw(OP_MULB,      CND_NEVER,     PC_START);
      PC_W'(2):  w = uw(OP_DINIT1,    CND_NEVER,     PC_START);
      PC_W'(3):  w = uw(OP_DINIT2,    CND_ALWAYS,    PC_EMIT + PC_W'(1));
      PC_W'(4):  w = uw(OP_NOP,       CND_IN_R2,     PC_R2);
      PC_W'(5):  w = uw(OP_NOP,       CND_D_NOT_POS, PC_R1_X);
      PC_W'(6):  w = uw(OP_YDEC,      CND_NEVER,     PC_START);
      PC_W'(7):  w = uw(OP_D_SUB_DY,  CND_NEVER,     PC_START);
      PC_W'(8):  w = uw(OP_XINC,      CND_NEVER,     PC_START);
      PC_W'(9):  w = uw(OP_D_ADD_BSQ, CND_NEVER,     PC_START);
      PC_W'(10): w = uw(OP_D_ADD_DX,  CND_DX_LT_DY,  PC_EMIT);
      PC_W'(11): w = uw(OP_T_DIFF,    CND_NEVER,     PC_START);
      PC_W'(12): w = uw(OP_T_TRIPLE,  CND_NEVER,     PC_START);
      PC_W'(13): w = uw(OP_T_HALF,    CND_NEVER,     PC_START);
      PC_W'(14): w = uw(OP_T_SUB_DX,  CND_NEVER,     PC_START);
      PC_W'(15): w = uw(OP_T_SUB_DY,  CND_NEVER,     PC_START);
      PC_W'(16): w = uw(OP_T_HALF,    CND_NEVER,     PC_START);
      PC_W'(17): w = uw(OP_D_ADD_T,   CND_NEVER,     PC_START);
      PC_W'(18): w = uw(OP_CHKY,      CND_ALWAYS,    PC_EMIT);
      PC_W'(19): w = uw(OP_NOP,       CND_D_NOT_NEG, PC_R2_Y);
      PC_W'(20): w = uw(OP_XINC,      CND_NEVER,     PC_START);
      PC_W'(21): w = uw(OP_D_ADD_DX,  CND_NEVER,     PC_START);
      PC_W'(22): w = uw(OP_YDEC,      CND_NEVER,     PC_START);
      PC_W'(23): w = uw(OP_D_ADD_ASQ, CND_NEVER,     PC_START);
      PC_W'(24): w = uw(OP_D_SUB_DY,  CND_NEVER,     PC_START);
      PC_W'(25): w = uw(OP_CHKY,      CND_NEVER,     PC_START);
      PC_W'(26): w = uw(OP_EMIT,      CND_NEVER,     PC_START);
      default:   w = uw(OP_FINISH,    CND_NEVER,     PC_START);
    endcase
    return w;
  endfunction

  // Signed halving that truncates toward zero
  function automatic logic signed [DEC_W-1:0] half_tz(input logic signed [DEC_W-1:0] t);
    logic signed [DEC_W-1:0] s;
    s = t + {{(DEC_W-1){1'b0}}, t[DEC_W-1]};
    return s >>> 1;
  endfunction

endpackage

### rtl/core/mer_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module mer_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_go,
  input  logic                step_go,
  input  mer_pkg::dp_flags_t  flags,
  output logic                busy,
  output mer_pkg::dp_ctl_t    ctl
);

  logic [mer_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     busy_r, busy_nxt;
  mer_pkg::uword_t          word;
  logic                     take;

  assign word = mer_pkg::ucode(pc_r);

  // Jump condition select
  always_comb begin
    case (word.cond)
      mer_pkg::CND_NEVER:     take = 1'b0;
      mer_pkg::CND_ALWAYS:    take = 1'b1;
      mer_pkg::CND_D_NOT_POS: take = !flags.d_pos;
      mer_pkg::CND_IN_R2:     take = flags.in_r2;
      mer_pkg::CND_D_NOT_NEG: take = !flags.d_neg;
      mer_pkg::CND_DX_LT_DY:  take = flags.dx_lt_dy;
      default:                take = 1'b0;
    endcase
  end

  // Next step; the emit step holds until its last result is loaded
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start_go) begin
      pc_nxt   = mer_pkg::PC_START;
      busy_nxt = 1'b1;
    end else if (step_go) begin
      pc_nxt   = mer_pkg::PC_STEP;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (word.op == mer_pkg::OP_EMIT) begin
        if (flags.emit_ok && flags.emit_last) pc_nxt = pc_r + mer_pkg::PC_W'(1);
      end else if (word.op == mer_pkg::OP_FINISH) begin
        busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + mer_pkg::PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= mer_pkg::PC_START;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy   = busy_r;
  assign ctl.en = busy_r;
  assign ctl.op = word.op;

endmodule

### rtl/core/mer_datapath.sv
// Ellipse datapath: decision terms, coordinates, result select and output register.
module mer_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start_go,
  input  logic                                   step_go,
  input  logic signed [mer_pkg::CENTER_W-1:0]    center_x,
  input  logic signed [mer_pkg::CENTER_W-1:0]    center_y,
  input  logic [mer_pkg::RIN_W-1:0]              radius_x,
  input  logic [mer_pkg::RIN_W-1:0]              radius_y,
  input  logic                                   fill_mode,
  input  logic [mer_pkg::CFG_W-1:0]              window_left,
  input  logic [mer_pkg::CFG_W-1:0]              window_top,
  input  mer_pkg::dp_ctl_t                       ctl,
  output mer_pkg::dp_flags_t                     flags,
  output logic                                   phase_idle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mer_pkg::COORD_W-1:0]     span_x_start,
  output logic signed [mer_pkg::COORD_W-1:0]     span_x_end,
  output logic signed [mer_pkg::COORD_W-1:0]     span_y,
  output logic                                   last_in_run,
  output logic                                   ellipse_done
);

  localparam int RB  = mer_pkg::RADIUS_BITS;
  localparam int SQ  = mer_pkg::SQ_W;
  localparam int PW  = mer_pkg::PROD_W;
  localparam int DL  = mer_pkg::DEL_W;
  localparam int DC  = mer_pkg::DEC_W;
  localparam int PS  = mer_pkg::POS_W;
  localparam int CW  = mer_pkg::COORD_W;

  mer_pkg::phase_t         phase_r, phase_nxt;
  logic                    fill_r, fill_nxt;
  logic signed [CW-1:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [PS-1:0]    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [RB-1:0]           ra_r, ra_nxt, rb_r, rb_nxt;
  logic [SQ-1:0]           a_sq_r, a_sq_nxt, b_sq_r, b_sq_nxt;
  logic [PW-1:0]           prod_r, prod_nxt;
  logic signed [DC-1:0]    dec_r, dec_nxt, tmp_r, tmp_nxt;
  logic signed [DL-1:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic                    done_r, done_nxt;
  logic [1:0]              k_r, k_nxt;
  logic signed [CW-1:0]    px_r, px_nxt, mx_r, mx_nxt, py_r, py_nxt, my_r, my_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [CW-1:0]    oxs_r, oxs_nxt, oxe_r, oxe_nxt, oy_r, oy_nxt;
  logic                    olast_r, olast_nxt, odone_r, odone_nxt;

  // Extended operands
  logic signed [DC-1:0]    asq_d, bsq_d, prod_d, dx_d, dy_d;
  logic [DL-1:0]           asq2, bsq2;
  logic signed [CW-1:0]    x_ext, y_ext;
  logic                    emit_ok, emit_last;
  logic signed [CW-1:0]    sel_xs, sel_xe, sel_y;

  assign asq_d  = {{(DC-SQ){1'b0}}, a_sq_r};
  assign bsq_d  = {{(DC-SQ){1'b0}}, b_sq_r};
  assign prod_d = {{(DC-PW){1'b0}}, prod_r};
  assign dx_d   = {{(DC-DL){dx_r[DL-1]}}, dx_r};
  assign dy_d   = {{(DC-DL){dy_r[DL-1]}}, dy_r};
  assign asq2   = {{(DL-SQ-1){1'b0}}, a_sq_r, 1'b0};
  assign bsq2   = {{(DL-SQ-1){1'b0}}, b_sq_r, 1'b0};
  // x only counts up from zero
  assign x_ext  = {{(CW-PS){1'b0}}, cur_x_r};
  assign y_ext  = {{(CW-PS){cur_y_r[PS-1]}}, cur_y_r};

  // Result slot handshake and result order
  assign emit_ok   = !ov_r || out_ready;
  assign emit_last = fill_r ? (k_r == 2'd1) : (k_r == 2'd3);

  always_comb begin
    if (fill_r) begin
      sel_xs = mx_r;
      sel_xe = px_r;
      sel_y  = k_r[0] ? py_r : my_r;
    end else begin
      sel_xs = k_r[0] ? mx_r : px_r;
      sel_xe = sel_xs;
      sel_y  = k_r[1] ? my_r : py_r;
    end
  end

  // Register transfers
  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    a_sq_nxt  = a_sq_r;
    b_sq_nxt  = b_sq_r;
    prod_nxt  = prod_r;
    dec_nxt   = dec_r;
    tmp_nxt   = tmp_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    done_nxt  = done_r;
    k_nxt     = k_r;
    px_nxt    = px_r;
    mx_nxt    = mx_r;
    py_nxt    = py_r;
    my_nxt    = my_r;
    ov_nxt    = ov_r;
    oxs_nxt   = oxs_r;
    oxe_nxt   = oxe_r;
    oy_nxt    = oy_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    if (start_go) begin
      // latch center with window offset, radii and mode
      cx_nxt   = CW'(center_x) + CW'(window_left);
      cy_nxt   = CW'(center_y) + CW'(window_top);
      fill_nxt = fill_mode;
      ra_nxt   = radius_x[RB-1:0];
      rb_nxt   = radius_y[RB-1:0];
    end else if (step_go) begin
      // snapshot mirrored coordinates before the update
      px_nxt   = cx_r + x_ext;
      mx_nxt   = cx_r - x_ext;
      py_nxt   = cy_r + y_ext;
      my_nxt   = cy_r - y_ext;
      done_nxt = 1'b0;
      k_nxt    = 2'd0;
    end else if (ctl.en) begin
      case (ctl.op)
        mer_pkg::OP_SQ: begin
          a_sq_nxt  = SQ'(ra_r) * SQ'(ra_r);
          b_sq_nxt  = SQ'(rb_r) * SQ'(rb_r);
          cur_x_nxt = '0;
          cur_y_nxt = {1'b0, rb_r};
          dx_nxt    = '0;
        end
        mer_pkg::OP_MULB:      prod_nxt = PW'(a_sq_r) * PW'(rb_r);
        mer_pkg::OP_DINIT1: begin
          dec_nxt = bsq_d + (asq_d >>> 2);
          dy_nxt  = DL'({prod_r, 1'b0});
        end
        mer_pkg::OP_DINIT2: begin
          dec_nxt   = dec_r - prod_d;
          phase_nxt = mer_pkg::PH_R1;
        end
        mer_pkg::OP_YDEC: begin
          cur_y_nxt = cur_y_r - PS'(1);
          dy_nxt    = dy_r - asq2;
        end
        mer_pkg::OP_XINC: begin
          cur_x_nxt = cur_x_r + PS'(1);
          dx_nxt    = dx_r + bsq2;
        end
        mer_pkg::OP_D_SUB_DY:  dec_nxt = dec_r - dy_d;
        mer_pkg::OP_D_ADD_BSQ: dec_nxt = dec_r + bsq_d;
        mer_pkg::OP_D_ADD_DX:  dec_nxt = dec_r + dx_d;
        mer_pkg::OP_D_ADD_ASQ: dec_nxt = dec_r + asq_d;
        mer_pkg::OP_T_DIFF:    tmp_nxt = asq_d - bsq_d;
        mer_pkg::OP_T_TRIPLE:  tmp_nxt = tmp_r + (tmp_r <<< 1);
        mer_pkg::OP_T_HALF:    tmp_nxt = mer_pkg::half_tz(tmp_r);
        mer_pkg::OP_T_SUB_DX:  tmp_nxt = tmp_r - dx_d;
        mer_pkg::OP_T_SUB_DY:  tmp_nxt = tmp_r - dy_d;
        mer_pkg::OP_D_ADD_T: begin
          dec_nxt   = dec_r + tmp_r;
          phase_nxt = mer_pkg::PH_R2;
        end
        mer_pkg::OP_CHKY: begin
          if (cur_y_r[PS-1]) begin
            phase_nxt = mer_pkg::PH_IDLE;
            done_nxt  = 1'b1;
          end
        end
        mer_pkg::OP_EMIT: begin
          if (emit_ok) begin
            ov_nxt    = 1'b1;
            oxs_nxt   = sel_xs;
            oxe_nxt   = sel_xe;
            oy_nxt    = sel_y;
            olast_nxt = emit_last;
            odone_nxt = done_r;
            k_nxt     = k_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mer_pkg::PH_IDLE;
      ov_r    <= 1'b0;
      done_r  <= 1'b0;
      k_r     <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
      done_r  <= done_nxt;
      k_r     <= k_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    fill_r  <= fill_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    a_sq_r  <= a_sq_nxt;
    b_sq_r  <= b_sq_nxt;
    prod_r  <= prod_nxt;
    dec_r   <= dec_nxt;
    tmp_r   <= tmp_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    px_r    <= px_nxt;
    mx_r    <= mx_nxt;
    py_r    <= py_nxt;
    my_r    <= my_nxt;
    oxs_r   <= oxs_nxt;
    oxe_r   <= oxe_nxt;
    oy_r    <= oy_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign flags.d_pos     = !dec_r[DC-1] && (dec_r != '0);
  assign flags.d_neg     = dec_r[DC-1];
  assign flags.dx_lt_dy  = dx_r < dy_r;
  assign flags.in_r2     = (phase_r == mer_pkg::PH_R2);
  assign flags.emit_ok   = emit_ok;
  assign flags.emit_last = emit_last;

  assign phase_idle   = (phase_r == mer_pkg::PH_IDLE);
  assign out_valid    = ov_r;
  assign span_x_start = oxs_r;
  assign span_x_end   = oxe_r;
  assign span_y       = oy_r;
  assign last_in_run  = olast_r;
  assign ellipse_done = odone_r;

endmodule

### rtl/core/midpoint_ellipse_rasterizer_core.sv
// Top level: configuration registers, stream unpacking and sequencer/datapath wiring.
// Start item: setup multiplies and decision terms, no results.
// Step item: region 1 or 2 microcode, then an emit step loading each result (2 fill,
// 4 outline), held by a full output; the region 1 to region 2 transition adds steps.
// One item is worked at a time, paced by the microcode; results leave through a
// one-entry output register. Synchronous active-low reset: idle, window offsets zero.
module midpoint_ellipse_rasterizer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [mer_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [mer_pkg::CFG_W-1:0]    cfg_wdata,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // center_x[15:0], center_y[31:16], radius_x[42:32], radius_y[53:43], fill_mode[54]
  input  logic [mer_pkg::TDATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic [0:0]                   in_tuser,
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // span_x_start[16:0], span_x_end[33:17], span_y[50:34]
  output logic [mer_pkg::TDATA_W-1:0]  out_tdata,
  // ellipse_done[0]
  output logic [0:0]                   out_tuser,
  output logic                         out_tlast
);

  logic [mer_pkg::CFG_W-1:0]   win_left_r, win_left_nxt;
  logic [mer_pkg::CFG_W-1:0]   win_top_r, win_top_nxt;
  logic                        busy, phase_idle, in_xfer, start_go, step_go;
  logic                        operation, fill_mode;
  logic signed [mer_pkg::CENTER_W-1:0] center_x, center_y;
  logic [mer_pkg::RIN_W-1:0]   radius_x, radius_y;
  logic signed [mer_pkg::COORD_W-1:0]  span_x_start, span_x_end, span_y;
  logic                        ellipse_done;
  mer_pkg::dp_ctl_t            ctl;
  mer_pkg::dp_flags_t          flags;

  // Configuration writes
  always_comb begin
    win_left_nxt = win_left_r;
    win_top_nxt  = win_top_r;
    if (cfg_we) begin
      case (cfg_addr)
        mer_pkg::CFG_WINDOW_LEFT: win_left_nxt = cfg_wdata;
        mer_pkg::CFG_WINDOW_TOP:  win_top_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r <= '0;
      win_top_r  <= '0;
    end else begin
      win_left_r <= win_left_nxt;
      win_top_r  <= win_top_nxt;
    end
  end

  // Input unpacking
  assign operation = in_tuser[0];
  assign center_x  = in_tdata[15:0];
  assign center_y  = in_tdata[31:16];
  assign radius_x  = in_tdata[42:32];
  assign radius_y  = in_tdata[53:43];
  assign fill_mode = in_tdata[54];

  // Item dispatch: zero radius starts and idle steps are dropped
  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;
  assign start_go  = in_xfer && (operation == mer_pkg::OPER_START)
                     && (radius_x[mer_pkg::RADIUS_BITS-1:0] != '0)
                     && (radius_y[mer_pkg::RADIUS_BITS-1:0] != '0);
  assign step_go   = in_xfer && (operation == mer_pkg::OPER_STEP) && !phase_idle;

  mer_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_go (start_go),
    .step_go  (step_go),
    .flags    (flags),
    .busy     (busy),
    .ctl      (ctl)
  );

  mer_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_go     (start_go),
    .step_go      (step_go),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .fill_mode    (fill_mode),
    .window_left  (win_left_r),
    .window_top   (win_top_r),
    .ctl          (ctl),
    .flags        (flags),
    .phase_idle   (phase_idle),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .span_x_start (span_x_start),
    .span_x_end   (span_x_end),
    .span_y       (span_y),
    .last_in_run  (out_tlast),
    .ellipse_done (ellipse_done)
  );

  // Result packing
  assign out_tdata = {{(mer_pkg::TDATA_W - 3*mer_pkg::COORD_W){1'b0}},
                      span_y, span_x_end, span_x_start};
  assign out_tuser = ellipse_done;

endmodule
